[sv/rtpswt_pkg.sv]
// Shared types and constants of the RTP sequence window tracker.
package rtpswt_pkg;

    localparam int STREAM_SLOTS = 4;
    localparam int WINDOW_SIZE  = 256;
    localparam int SLOT_W       = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int WIN_WORDS    = (WINDOW_SIZE + 63) / 64;
    localparam int WORD_W       = (WIN_WORDS > 1) ? $clog2(WIN_WORDS) : 1;
    localparam int WADDR_W      = $clog2(STREAM_SLOTS * WIN_WORDS);
    localparam int OFF_W        = $clog2(WINDOW_SIZE);

    localparam logic [2:0] ST_INVALID = 3'd0;
    localparam logic [2:0] ST_NEW     = 3'd1;
    localparam logic [2:0] ST_HIGHEST = 3'd2;
    localparam logic [2:0] ST_FILL    = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;
    localparam logic [2:0] ST_OLD     = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOKUP, S_CLASSIFY, S_SHIFT, S_TEST, S_OUTPUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an input beat
        logic lookup;    // match the SSRC and classify
        logic classify;  // extend the number, pick the window path
        logic shift;     // move one window word along
        logic test;      // read/test the target bit, update the slot
        logic emit;      // present the result
    } t_cmd;

    typedef struct packed {
        logic early_done;  // invalid, full or new stream: no window work
        logic advance;     // the window must be moved along
        logic shift_last;  // the last window word is being moved
    } t_stat;

endpackage

[sv/rtpswt_ctrl.sv]
// Controller state machine of the RTP sequence window tracker.
module rtpswt_ctrl
    import rtpswt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = S_CLASSIFY;
            end
            S_CLASSIFY: begin
                if (i_stat.early_done) begin
                    n_state = S_OUTPUT;
                end else begin
                    o_cmd.classify = 1'b1;
                    n_state = i_stat.advance ? S_SHIFT : S_TEST;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                o_cmd.test = 1'b1;
                n_state = S_OUTPUT;
            end
            S_OUTPUT: begin
                o_out_valid = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid));

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready);

    a_shift_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT && i_stat.shift_last |=> r_state == S_TEST);

endmodule

[sv/rtpswt_dp.sv]
// Datapath of the RTP sequence window tracker: slot table, window memory, counters.
module rtpswt_dp
    import rtpswt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic [7:0]   i_hdr,
    input  logic [15:0]  i_len,
    input  logic [15:0]  i_seq,
    input  logic [31:0]  i_ssrc,
    input  logic [63:0]  i_ts,
    input  logic         i_h264,
    output logic [2:0]   o_status,
    output logic [1:0]   o_slot,
    output logic [31:0]  o_ext,
    output logic [31:0]  o_unique,
    output logic [31:0]  o_dup,
    output logic [31:0]  o_old,
    output logic [31:0]  o_ooo,
    output logic [31:0]  o_lost,
    output logic         o_h264,
    output logic [63:0]  o_first_ts,
    output logic [63:0]  o_last_ts
);

    logic [STREAM_SLOTS-1:0] r_valid;
    logic [31:0] r_ssrc_t  [STREAM_SLOTS];
    logic [15:0] r_maxs_t  [STREAM_SLOTS];
    logic [15:0] r_wrap_t  [STREAM_SLOTS];
    logic [31:0] r_high_t  [STREAM_SLOTS];
    logic [31:0] r_base_t  [STREAM_SLOTS];
    logic [31:0] r_uniq_t  [STREAM_SLOTS];
    logic [31:0] r_dup_t   [STREAM_SLOTS];
    logic [31:0] r_old_t   [STREAM_SLOTS];
    logic [31:0] r_ooo_t   [STREAM_SLOTS];
    logic [63:0] r_fts_t   [STREAM_SLOTS];
    logic [63:0] r_lts_t   [STREAM_SLOTS];
    logic        r_h264_t  [STREAM_SLOTS];
    logic [63:0] r_win [WIN_WORDS];
    logic [63:0] r_shbuf [WIN_WORDS];

    logic [7:0]  r_hdr;
    logic [15:0] r_len, r_seq;
    logic [31:0] r_ssrc;
    logic [63:0] r_ts;
    logic        r_h264;

    logic              r_early;
    logic [SLOT_W-1:0] r_k;
    logic [2:0]        r_status;
    logic [31:0]       r_ext;
    logic [15:0]       r_wrap;
    logic [WORD_W-1:0] r_widx;
    logic [63:0]       r_carry;
    logic [WORD_W:0]   r_wsh;
    logic [5:0]        r_bsh;
    logic              r_adv;

    // Lookup over the table.
    logic              l_found, l_free;
    logic [SLOT_W-1:0] l_fk, l_freek;
    always_comb begin
        l_found = 1'b0;
        l_free  = 1'b0;
        l_fk    = '0;
        l_freek = '0;
        for (int i = 0; i < STREAM_SLOTS; i++) begin
            if (!l_found && r_valid[i] && r_ssrc_t[i] == r_ssrc) begin
                l_found = 1'b1;
                l_fk = SLOT_W'(i);
            end
            if (!r_valid[i] && !l_free) begin
                l_free = 1'b1;
                l_freek = SLOT_W'(i);
            end
        end
    end

    logic l_bad;
    assign l_bad = (r_len < 16'd12) || (r_hdr[7:6] != 2'd2);

    // Extension.
    logic [15:0] c_wrap, c_diff;
    logic [31:0] c_ext;
    always_comb begin
        c_diff = r_seq - r_maxs_t[r_k];
        c_wrap = r_wrap_t[r_k];
        if (c_diff < 16'h8000 && r_seq < r_maxs_t[r_k]) begin
            c_wrap = c_wrap + 16'd1;
        end
        c_ext = {c_wrap, r_seq};
    end

    logic [31:0] c_delta;
    assign c_delta = c_ext - r_high_t[r_k];

    assign o_stat.early_done = r_early;
    assign o_stat.advance    = (c_ext > r_high_t[r_k]);
    assign o_stat.shift_last = (r_widx == WORD_W'(WIN_WORDS - 1));

    // Window word address: slot's words live in one row selected per stream.
    logic [63:0] r_wmem [STREAM_SLOTS * WIN_WORDS];
    logic [WADDR_W-1:0] c_base;
    assign c_base = WADDR_W'(r_k) * WADDR_W'(WIN_WORDS);

    // Offset of the target bit after any advance.
    logic [31:0]      c_off;
    logic [OFF_W-1:0] c_offb;
    assign c_off  = r_adv ? 32'd0 : (r_high_t[r_k] - r_ext);
    assign c_offb = c_off[OFF_W-1:0];

    logic [63:0] c_src, c_shw;
    logic [WORD_W:0] c_srci;
    always_comb begin
        c_srci = {1'b0, r_widx} - r_wsh;
        c_src = c_srci[WORD_W] ? 64'd0 : r_win[c_srci[WORD_W-1:0]];
        c_shw = (c_src << r_bsh) | ((r_bsh != 6'd0) ? r_carry : 64'd0);
    end

    logic [63:0] c_tword;
    logic        c_tbit;
    assign c_tword = r_win[c_offb[OFF_W-1:6]];
    assign c_tbit  = c_tword[c_offb[5:0]];

    logic        c_tbit_sh;
    assign c_tbit_sh = r_shbuf[0][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.lookup && !l_bad && !l_found && l_free) begin
            r_valid[l_freek] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hdr <= i_hdr; r_len <= i_len; r_seq <= i_seq;
            r_ssrc <= i_ssrc; r_ts <= i_ts; r_h264 <= i_h264;
        end
        if (i_cmd.lookup) begin
            r_early <= l_bad || !l_found;
            r_k <= l_found ? l_fk : l_freek;
            r_widx <= '0;
            if (l_bad) begin
                r_status <= ST_INVALID;
            end else if (!l_found && !l_free) begin
                r_status <= ST_FULL;
            end else if (!l_found) begin
                r_status <= ST_NEW;
                r_ext <= {16'd0, r_seq};
                r_ssrc_t[l_freek] <= r_ssrc;
                r_maxs_t[l_freek] <= r_seq;
                r_wrap_t[l_freek] <= '0;
                r_base_t[l_freek] <= {16'd0, r_seq};
                r_high_t[l_freek] <= {16'd0, r_seq};
                r_uniq_t[l_freek] <= 32'd1;
                r_dup_t[l_freek] <= '0;
                r_old_t[l_freek] <= '0;
                r_ooo_t[l_freek] <= '0;
                r_fts_t[l_freek] <= r_ts;
                r_lts_t[l_freek] <= r_ts;
                r_h264_t[l_freek] <= r_h264;
                for (int j = 0; j < WIN_WORDS; j++) begin
                    r_win[j] <= (j == 0) ? 64'd1 : 64'd0;
                end
            end else begin
                for (int j = 0; j < WIN_WORDS; j++) begin
                    r_win[j] <= r_wmem[WADDR_W'(l_fk) * WADDR_W'(WIN_WORDS)
                                       + WADDR_W'(j)];
                end
            end
        end
        if (i_cmd.classify) begin
            r_ext <= c_ext;
            r_wrap <= c_wrap;
            r_adv <= (c_ext > r_high_t[r_k]);
            r_carry <= '0;
            r_lts_t[r_k] <= r_ts;
            if (r_h264) begin
                r_h264_t[r_k] <= 1'b1;
            end
            if (c_delta >= 32'(WINDOW_SIZE)) begin
                r_wsh <= (WORD_W+1)'(WIN_WORDS);
            end else begin
                r_wsh <= (WORD_W+1)'(c_delta[OFF_W-1:6]);
            end
            r_bsh <= (c_delta >= 32'(WINDOW_SIZE)) ? 6'd0 : c_delta[5:0];
        end
        if (i_cmd.shift) begin
            // Words are built from the bottom up into a separate buffer; the carry
            // holds the bits that spill out of the word below.
            r_widx <= r_widx + WORD_W'(1);
            r_carry <= (r_bsh != 6'd0) ? (c_src >> (7'd64 - {1'b0, r_bsh})) : 64'd0;
            r_shbuf[r_widx] <= c_shw;
        end
        if (i_cmd.test) begin
            if (r_adv) begin
                r_high_t[r_k] <= r_ext;
                r_maxs_t[r_k] <= r_seq;
                r_wrap_t[r_k] <= r_wrap;
                // The moved window replaces the held one; offset 0 is the new highest.
                for (int j = 0; j < WIN_WORDS; j++) begin
                    r_win[j] <= (j == 0 && !c_tbit_sh) ? (r_shbuf[0] | 64'd1) : r_shbuf[j];
                end
                if (c_tbit_sh) begin
                    r_dup_t[r_k] <= r_dup_t[r_k] + 32'd1;
                    r_status <= ST_DUP;
                end else begin
                    r_uniq_t[r_k] <= r_uniq_t[r_k] + 32'd1;
                    r_status <= ST_HIGHEST;
                end
            end else if (c_off >= 32'(WINDOW_SIZE)) begin
                r_old_t[r_k] <= r_old_t[r_k] + 32'd1;
                r_status <= ST_OLD;
            end else if (c_tbit) begin
                r_dup_t[r_k] <= r_dup_t[r_k] + 32'd1;
                r_status <= ST_DUP;
            end else begin
                r_win[c_offb[OFF_W-1:6]] <= c_tword | (64'd1 << c_offb[5:0]);
                r_uniq_t[r_k] <= r_uniq_t[r_k] + 32'd1;
                if (c_off != 32'd0) begin
                    r_ooo_t[r_k] <= r_ooo_t[r_k] + 32'd1;
                end
                r_status <= ST_FILL;
            end
        end
        if (i_cmd.emit && r_status != ST_INVALID && r_status != ST_FULL) begin
            for (int j = 0; j < WIN_WORDS; j++) begin
                r_wmem[c_base + WADDR_W'(j)] <= r_win[j];
            end
        end
    end

    logic [31:0] c_exp;
    assign c_exp = r_high_t[r_k] - r_base_t[r_k] + 32'd1;

    logic c_ok;
    assign c_ok = (r_status != ST_INVALID) && (r_status != ST_FULL);

    assign o_status   = r_status;
    assign o_slot     = c_ok ? 2'(r_k) : 2'd0;
    assign o_ext      = c_ok ? r_ext : 32'd0;
    assign o_unique   = c_ok ? r_uniq_t[r_k] : 32'd0;
    assign o_dup      = c_ok ? r_dup_t[r_k] : 32'd0;
    assign o_old      = c_ok ? r_old_t[r_k] : 32'd0;
    assign o_ooo      = c_ok ? r_ooo_t[r_k] : 32'd0;
    assign o_lost     = (c_ok && r_uniq_t[r_k] < c_exp) ? (c_exp - r_uniq_t[r_k]) : 32'd0;
    assign o_h264     = c_ok ? r_h264_t[r_k] : 1'b0;
    assign o_first_ts = c_ok ? r_fts_t[r_k] : 64'd0;
    assign o_last_ts  = c_ok ? r_lts_t[r_k] : 64'd0;

endmodule

[sv/rtp_sequence_window_tracker.sv]
// Top level of the RTP sequence window tracker.
// Each slave beat carries one RTP packet's header fields; each master beat
// carries the stream statistics after that packet is processed.
// One result beat follows every input beat, in order.
// An invalid packet, a full table or a new stream skips the window work and goes
// straight to the result; a known stream is also classified and tested, and when its
// highest number advances the window (4 words of 64 bits) is first moved a word a cycle.
// The next beat is taken only after the result beat has been taken, so only one
// packet is in flight at a time.
// After reset every stream slot is free; slot contents are written when a
// stream starts. A stall on the master side holds the result stable and
// blocks the slave side until it clears.
module rtp_sequence_window_tracker
    import rtpswt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] header_first_byte, [23:8] packet_length, [39:24] seq_number,
    // [71:40] ssrc, [135:72] timestamp_us, [136] h264_seen, zero fill to 144
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [4:3] stream_slot, [36:5] extended_seq, [68:37] unique_count,
    // [100:69] duplicate_total, [132:101] too_old_total, [164:133] out_of_order_total,
    // [196:165] lost_estimate, [197] stream_h264, [261:198] first_timestamp_us,
    // [325:262] last_timestamp_us, zero fill to 328
    output logic [327:0] m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rtpswt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    rtpswt_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .i_hdr(s_axis_tdata[7:0]), .i_len(s_axis_tdata[23:8]),
        .i_seq(s_axis_tdata[39:24]), .i_ssrc(s_axis_tdata[71:40]),
        .i_ts(s_axis_tdata[135:72]), .i_h264(s_axis_tdata[136]),
        .o_status(m_axis_tdata[2:0]), .o_slot(m_axis_tdata[4:3]),
        .o_ext(m_axis_tdata[36:5]), .o_unique(m_axis_tdata[68:37]),
        .o_dup(m_axis_tdata[100:69]), .o_old(m_axis_tdata[132:101]),
        .o_ooo(m_axis_tdata[164:133]), .o_lost(m_axis_tdata[196:165]),
        .o_h264(m_axis_tdata[197]), .o_first_ts(m_axis_tdata[261:198]),
        .o_last_ts(m_axis_tdata[325:262])
    );

    assign m_axis_tdata[327:326] = 2'b00;

endmodule
